/* hw/rtl/sdsl_pkg.sv */
// Shared types, constants, tanh table and helpers for the stereo duck/soft-clip limiter.
package sdsl_pkg;

   // Table geometry
   localparam int TANH_TABLE_DEPTH = 256;
   localparam int TANH_IDX_W       = $clog2(TANH_TABLE_DEPTH);
   localparam int TANH_ADDR_W      = $clog2(TANH_TABLE_DEPTH + 1);
   localparam int TANH_P_W         = 18 + TANH_IDX_W;

   // Register indexes
   localparam logic [2:0] CSR_AMB_GAIN  = 3'd0;
   localparam logic [2:0] CSR_MUS_GAIN  = 3'd1;
   localparam logic [2:0] CSR_WEA_LEVEL = 3'd2;
   localparam logic [2:0] CSR_MST_GAIN  = 3'd3;
   localparam logic [2:0] CSR_MUS_EN    = 3'd4;

   // Fixed-point constants (Q16 unless noted)
   localparam int K_WEA_SCALE = 9011;   // 0.55 in Q14
   localparam int K_PRE       = 55706;  // 0.85
   localparam int K_POST      = 75366;  // 1.15
   localparam int K_KNEE      = 58982;  // 0.9
   localparam int K_KNEE_INV  = 80100;  // 1.1/0.9
   localparam int K_WEA_MAX   = 22938;  // 0.35
   localparam int K_MUS_MAX   = 13107;  // 0.2
   localparam int K_ATT_KEEP  = 60293;  // 0.92
   localparam int K_ATT_NEW   = 5243;   // 0.08
   localparam int K_REL_KEEP  = 65208;  // 0.995
   localparam int K_REL_NEW   = 328;    // 0.005
   localparam int K_GAIN_MIN  = 39322;  // 0.6
   localparam int K_GAIN_NEW  = 6554;   // 0.1
   localparam int K_ONE       = 65536;

   // Sequencer steps
   localparam logic [4:0] S_AMB_L    = 5'd0;
   localparam logic [4:0] S_AMB_R    = 5'd1;
   localparam logic [4:0] S_MUS_L    = 5'd2;
   localparam logic [4:0] S_MUS_R    = 5'd3;
   localparam logic [4:0] S_WEA_L    = 5'd4;
   localparam logic [4:0] S_WEA_L2   = 5'd5;
   localparam logic [4:0] S_WEA_R    = 5'd6;
   localparam logic [4:0] S_WEA_R2   = 5'd7;
   localparam logic [4:0] S_DUCK_M   = 5'd8;
   localparam logic [4:0] S_MDK_L    = 5'd9;
   localparam logic [4:0] S_MDK_R    = 5'd10;
   localparam logic [4:0] S_DUCK_A   = 5'd11;
   localparam logic [4:0] S_ADK_L    = 5'd12;
   localparam logic [4:0] S_ADK_R    = 5'd13;
   localparam logic [4:0] S_SUM      = 5'd14;
   localparam logic [4:0] S_SC_PRE   = 5'd15;
   localparam logic [4:0] S_SC_SEG1  = 5'd16;
   localparam logic [4:0] S_SC_INT1  = 5'd17;
   localparam logic [4:0] S_SC_GAIN  = 5'd18;
   localparam logic [4:0] S_SC_PRE2  = 5'd19;
   localparam logic [4:0] S_SC_SEG2  = 5'd20;
   localparam logic [4:0] S_SC_INT2  = 5'd21;
   localparam logic [4:0] S_SC_FIN   = 5'd22;
   localparam logic [4:0] S_ENV_A    = 5'd23;
   localparam logic [4:0] S_ENV_B    = 5'd24;
   localparam logic [4:0] S_GAIN_CHK = 5'd25;
   localparam logic [4:0] S_GAIN_A   = 5'd26;
   localparam logic [4:0] S_GAIN_B   = 5'd27;
   localparam logic [4:0] S_OUT_L1   = 5'd28;
   localparam logic [4:0] S_OUT_L2   = 5'd29;
   localparam logic [4:0] S_OUT_R1   = 5'd30;
   localparam logic [4:0] S_OUT_R2   = 5'd31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DIV,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic [4:0] shift;
      logic       round;
   } mac_ctl_type;

   typedef struct packed {
      logic [16:0] lo;
      logic [16:0] diff;
      logic [17:0] frac;
      logic        neg;
   } tanh_seg_type;

   typedef logic [16:0] tanh_tab_type [TANH_TABLE_DEPTH + 1];

   // Build tanh(4*i/DEPTH) in Q16 from a Taylor series of exp(-2x) and squarings
   function automatic tanh_tab_type build_tanh_tab();
      tanh_tab_type       tab;
      logic [63:0]        xq;
      logic [63:0]        t;
      logic [63:0]        t2;
      logic [63:0]        t3;
      logic [63:0]        t4;
      logic [63:0]        e;
      logic [63:0]        num;
      logic [63:0]        den;
      logic [63:0]        rem;
      logic [63:0]        quo;
      logic signed [63:0] es;
      logic signed [63:0] q30;
      q30 = 64'sd1 <<< 30;
      for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
         xq = (64'(i) << 18) / TANH_TABLE_DEPTH;
         t  = xq << 7;
         t2 = (t * t) >> 30;
         t3 = (t2 * t) >> 30;
         t4 = (t3 * t) >> 30;
         es = q30 - $signed(t) + $signed(t2 / 2) - $signed(t3 / 6) + $signed(t4 / 24);
         if (es < 0) es = 0;
         if (es > q30) es = q30;
         e = es;
         for (int k = 0; k < 8; k++) e = (e * e) >> 30;
         den = 64'(q30) + e;
         num = ((64'(q30) - e) << 16) + (den >> 1);
         // Long division, one bit a step
         rem = '0;
         quo = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
               rem    = rem - den;
               quo[b] = 1'b1;
            end
         end
         tab[i] = quo[16:0];
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh_tab();

   function automatic logic [20:0] abs21(logic signed [20:0] v);
      return v[20] ? 21'(~v + 21'sd1) : 21'(v);
   endfunction

   function automatic logic signed [15:0] sat16(logic signed [41:0] v);
      if (v > 42'sd32767) return 16'sh7fff;
      if (v < -42'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic [17:0] sat18(logic signed [41:0] v);
      if (v < 42'sd0) return 18'd0;
      if (v > 42'sd262143) return 18'h3ffff;
      return v[17:0];
   endfunction

endpackage

/* hw/rtl/sdsl_mac.sv */
// Shared multiply-accumulate unit with round-half-up and arithmetic right shift.
module sdsl_mac (
   input  logic signed [20:0]   mac_a,
   input  logic signed [19:0]   mac_b,
   input  logic signed [41:0]   mac_add,
   input  sdsl_pkg::mac_ctl_type mac_ctl,
   output logic signed [41:0]   mac_res
);
   import sdsl_pkg::*;

   logic signed [41:0] prod;
   logic signed [41:0] half;
   logic signed [41:0] sum;

   // Multiply, add bias and rounding half, then shift down
   always_comb begin
      prod    = 42'(mac_a) * 42'(mac_b);
      half    = mac_ctl.round ? (42'sd1 <<< (mac_ctl.shift - 5'd1)) : 42'sd0;
      sum     = prod + mac_add + half;
      mac_res = sum >>> mac_ctl.shift;
   end

endmodule

/* hw/rtl/sdsl_tanh_lut.sv */
// Tanh table lookup: splits |x| into a table segment and interpolation fraction.
module sdsl_tanh_lut (
   input  logic signed [20:0]     lut_x,
   output sdsl_pkg::tanh_seg_type lut_seg
);
   import sdsl_pkg::*;

   logic [20:0]            mag;
   logic                   over;
   logic [TANH_P_W-1:0]    pos;
   logic [TANH_ADDR_W-1:0] idx_lo;
   logic [TANH_ADDR_W-1:0] idx_hi;
   logic [16:0]            tab_lo;
   logic [16:0]            tab_hi;

   // Locate segment, saturate at the table end
   always_comb begin
      mag    = abs21(lut_x);
      over   = (mag >= 21'd262144);
      pos    = TANH_P_W'(mag[17:0]) * TANH_P_W'(TANH_TABLE_DEPTH);
      idx_lo = TANH_ADDR_W'(pos[TANH_P_W-1:18]);
      idx_hi = idx_lo + TANH_ADDR_W'(1);
      tab_lo = TANH_TAB[idx_lo];
      tab_hi = TANH_TAB[idx_hi];
      lut_seg.neg = lut_x[20];
      if (over) begin
         lut_seg.lo   = TANH_TAB[TANH_TABLE_DEPTH];
         lut_seg.diff = '0;
         lut_seg.frac = '0;
      end else begin
         lut_seg.lo   = tab_lo;
         lut_seg.diff = tab_hi - tab_lo;
         lut_seg.frac = pos[17:0];
      end
   end

endmodule

/* hw/rtl/stereo_duck_softclip_limiter_top.sv */
// Top level of the stereo duck, soft-clip and limiter mixer.
//
//  channel | ports                      | beat
//  --------+----------------------------+-------------------------------------
//  req     | req_valid / req_ready      | six Q1.15 source samples
//  rsp     | rsp_valid / rsp_ready      | out_left, out_right, mono_mix
//  csr     | csr_we, csr_index, csr_wdata | one register write, no wait
//
// Each frame runs through the shared multiplier sequencer (the soft-clip
// steps run once per channel), then loads the output register and returns
// to idle before the next request is accepted. The restoring divider also
// runs, before the limiter gain update, when the limiter envelope is above
// one.
// A finished frame waits in the sequencer while the output register still
// holds an unaccepted beat. The next request is taken only once the sequencer
// is idle.
// Reset is synchronous and restores registers and limiter state.
module stereo_duck_softclip_limiter_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_ambience_left,
   input  logic signed [15:0] req_ambience_right,
   input  logic signed [15:0] req_music_left,
   input  logic signed [15:0] req_music_right,
   input  logic signed [15:0] req_weather_left,
   input  logic signed [15:0] req_weather_right,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_out_left,
   output logic signed [15:0] rsp_out_right,
   output logic signed [15:0] rsp_mono_mix,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [14:0]        csr_wdata
);
   import sdsl_pkg::*;

   state_type          state_ff, state_in;
   logic [4:0]         step_ff, step_in;
   logic               ch_ff, ch_in;
   logic               up_ff, up_in;
   logic               big_ff, big_in;
   logic [3:0]         dcnt_ff, dcnt_in;
   logic [18:0]        rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;

   logic [14:0]        ag_ff, ag_in;
   logic [14:0]        mg_ff, mg_in;
   logic [14:0]        wg_ff, wg_in;
   logic [14:0]        gm_ff, gm_in;
   logic               men_ff, men_in;

   logic signed [15:0] s_al_ff, s_al_in, s_ar_ff, s_ar_in;
   logic signed [15:0] s_ml_ff, s_ml_in, s_mr_ff, s_mr_in;
   logic signed [15:0] s_wl_ff, s_wl_in, s_wr_ff, s_wr_in;

   logic signed [20:0] al_ff, al_in, ar_ff, ar_in;
   logic signed [20:0] ml_ff, ml_in, mr_ff, mr_in;
   logic signed [20:0] wl_ff, wl_in, wr_ff, wr_in;
   logic signed [20:0] t_ff, t_in, y_ff, y_in;
   logic signed [20:0] yl_ff, yl_in, yr_ff, yr_in;
   logic [16:0]        dk_ff, dk_in;
   logic [17:0]        env_ff, env_in;
   logic [17:0]        gs_ff, gs_in;
   logic signed [41:0] acc_ff, acc_in;
   tanh_seg_type       seg_ff, seg_in;
   logic signed [15:0] ol_ff, ol_in, or_ff, or_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] out_l_ff, out_l_in, out_r_ff, out_r_in, mono_ff, mono_in;

   logic signed [20:0] mac_a;
   logic signed [19:0] mac_b;
   logic signed [41:0] mac_add;
   mac_ctl_type        mac_ctl;
   logic signed [41:0] mac_res;
   tanh_seg_type       lut_seg;

   logic [20:0]        peak;
   logic               up_now;
   logic [16:0]        gcl;
   logic [21:0]        abs_sum;
   logic [23:0]        mus_env;
   logic [14:0]        lvl;
   logic [18:0]        rem_sh;
   logic signed [20:0] fin;
   logic signed [20:0] ires;
   logic signed [16:0] lr_sum;

   sdsl_mac u_mac (
      .mac_a   (mac_a),
      .mac_b   (mac_b),
      .mac_add (mac_add),
      .mac_ctl (mac_ctl),
      .mac_res (mac_res)
   );

   sdsl_tanh_lut u_lut (
      .lut_x   (t_ff),
      .lut_seg (lut_seg)
   );

   // Shared values from stored state
   always_comb begin
      peak   = (abs21(yl_ff) > abs21(yr_ff)) ? abs21(yl_ff) : abs21(yr_ff);
      up_now = (peak > 21'(env_ff));
      gcl    = (quo_ff >= 16'(K_GAIN_MIN)) ? {1'b0, quo_ff} : 17'(K_GAIN_MIN);
   end

   // Select multiplier operands for the current step
   always_comb begin
      mac_a   = '0;
      mac_b   = '0;
      mac_add = '0;
      mac_ctl = '{shift: 5'd0, round: 1'b0};
      unique case (step_ff)
         S_AMB_L: begin
            mac_a = 21'(s_al_ff); mac_b = $signed({5'b0, ag_ff});
            mac_ctl = '{shift: 5'd13, round: 1'b1};
         end
         S_AMB_R: begin
            mac_a = 21'(s_ar_ff); mac_b = $signed({5'b0, ag_ff});
            mac_ctl = '{shift: 5'd13, round: 1'b1};
         end
         S_MUS_L: begin
            mac_a = men_ff ? 21'(s_ml_ff) : 21'sd0; mac_b = $signed({5'b0, mg_ff});
            mac_ctl = '{shift: 5'd13, round: 1'b1};
         end
         S_MUS_R: begin
            mac_a = men_ff ? 21'(s_mr_ff) : 21'sd0; mac_b = $signed({5'b0, mg_ff});
            mac_ctl = '{shift: 5'd13, round: 1'b1};
         end
         S_WEA_L: begin
            mac_a = 21'(s_wl_ff); mac_b = $signed({5'b0, wg_ff});
            mac_ctl = '{shift: 5'd13, round: 1'b1};
         end
         S_WEA_L2: begin
            mac_a = wl_ff; mac_b = 20'(K_WEA_SCALE);
            mac_ctl = '{shift: 5'd14, round: 1'b1};
         end
         S_WEA_R: begin
            mac_a = 21'(s_wr_ff); mac_b = $signed({5'b0, wg_ff});
            mac_ctl = '{shift: 5'd13, round: 1'b1};
         end
         S_WEA_R2: begin
            mac_a = wr_ff; mac_b = 20'(K_WEA_SCALE);
            mac_ctl = '{shift: 5'd14, round: 1'b1};
         end
         S_MDK_L: begin
            mac_a = ml_ff; mac_b = $signed({3'b0, dk_ff});
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_MDK_R: begin
            mac_a = mr_ff; mac_b = $signed({3'b0, dk_ff});
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_ADK_L: begin
            mac_a = al_ff; mac_b = $signed({3'b0, dk_ff});
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_ADK_R: begin
            mac_a = ar_ff; mac_b = $signed({3'b0, dk_ff});
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_SC_PRE: begin
            mac_a = ch_ff ? ar_ff : al_ff; mac_b = 20'(K_PRE);
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_SC_INT1, S_SC_INT2: begin
            mac_a   = $signed({4'b0, seg_ff.diff});
            mac_b   = $signed({2'b0, seg_ff.frac});
            mac_add = 42'($signed({1'b0, seg_ff.lo, 18'b0}));
            mac_ctl = '{shift: 5'd18, round: 1'b0};
         end
         S_SC_GAIN: begin
            mac_a = t_ff; mac_b = 20'(K_POST);
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_SC_PRE2: begin
            mac_a = y_ff; mac_b = 20'(K_KNEE_INV);
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_SC_FIN: begin
            mac_a = t_ff; mac_b = 20'(K_KNEE);
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_ENV_A: begin
            mac_a = $signed({3'b0, env_ff});
            mac_b = up_now ? 20'(K_ATT_KEEP) : 20'(K_REL_KEEP);
         end
         S_ENV_B: begin
            mac_a   = $signed(peak);
            mac_b   = up_ff ? 20'(K_ATT_NEW) : 20'(K_REL_NEW);
            mac_add = acc_ff;
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_GAIN_A: begin
            mac_a = $signed({3'b0, gs_ff});
            mac_b = big_ff ? 20'(K_KNEE) : 20'(K_REL_KEEP);
         end
         S_GAIN_B: begin
            mac_a   = big_ff ? $signed({4'b0, gcl}) : 21'(K_ONE);
            mac_b   = big_ff ? 20'(K_GAIN_NEW) : 20'(K_REL_NEW);
            mac_add = acc_ff;
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_OUT_L1: begin
            mac_a = yl_ff; mac_b = $signed({2'b0, gs_ff});
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         S_OUT_L2, S_OUT_R2: begin
            mac_a = t_ff; mac_b = $signed({5'b0, gm_ff});
            mac_ctl = '{shift: 5'd15, round: 1'b1};
         end
         S_OUT_R1: begin
            mac_a = yr_ff; mac_b = $signed({2'b0, gs_ff});
            mac_ctl = '{shift: 5'd16, round: 1'b1};
         end
         default: begin
            mac_a = '0;
         end
      endcase
   end

   // Next state, datapath writes and output register
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      ch_in    = ch_ff;
      up_in    = up_ff;
      big_in   = big_ff;
      dcnt_in  = dcnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      ag_in    = ag_ff;
      mg_in    = mg_ff;
      wg_in    = wg_ff;
      gm_in    = gm_ff;
      men_in   = men_ff;
      s_al_in  = s_al_ff;
      s_ar_in  = s_ar_ff;
      s_ml_in  = s_ml_ff;
      s_mr_in  = s_mr_ff;
      s_wl_in  = s_wl_ff;
      s_wr_in  = s_wr_ff;
      al_in    = al_ff;
      ar_in    = ar_ff;
      ml_in    = ml_ff;
      mr_in    = mr_ff;
      wl_in    = wl_ff;
      wr_in    = wr_ff;
      t_in     = t_ff;
      y_in     = y_ff;
      yl_in    = yl_ff;
      yr_in    = yr_ff;
      dk_in    = dk_ff;
      env_in   = env_ff;
      gs_in    = gs_ff;
      acc_in   = acc_ff;
      seg_in   = seg_ff;
      ol_in    = ol_ff;
      or_in    = or_ff;
      out_l_in = out_l_ff;
      out_r_in = out_r_ff;
      mono_in  = mono_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      abs_sum  = '0;
      mus_env  = '0;
      lvl      = '0;
      rem_sh   = {rem_ff[17:0], 1'b0};
      fin      = '0;
      ires     = mac_res[20:0];
      lr_sum   = '0;

      // Register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_AMB_GAIN:  ag_in = csr_wdata;
            CSR_MUS_GAIN:  mg_in = csr_wdata;
            CSR_WEA_LEVEL: wg_in = (csr_wdata > 15'd16384) ? 15'd16384 : csr_wdata;
            CSR_MST_GAIN:  gm_in = csr_wdata;
            CSR_MUS_EN:    men_in = csr_wdata[0];
            default:       ag_in = ag_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               s_al_in  = req_ambience_left;
               s_ar_in  = req_ambience_right;
               s_ml_in  = req_music_left;
               s_mr_in  = req_music_right;
               s_wl_in  = req_weather_left;
               s_wr_in  = req_weather_right;
               state_in = ST_RUN;
               step_in  = S_AMB_L;
               ch_in    = 1'b0;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 5'd1;
            unique case (step_ff)
               S_AMB_L:  al_in = ires;
               S_AMB_R:  ar_in = ires;
               S_MUS_L:  ml_in = ires;
               S_MUS_R:  mr_in = ires;
               S_WEA_L, S_WEA_L2: wl_in = ires;
               S_WEA_R, S_WEA_R2: wr_in = ires;
               S_DUCK_M: begin
                  abs_sum = 22'(abs21(wl_ff)) + 22'(abs21(wr_ff));
                  lvl     = (abs_sum > 22'(K_WEA_MAX)) ? 15'(K_WEA_MAX) : abs_sum[14:0];
                  dk_in   = 17'(K_ONE) - 17'((16'(lvl) + 16'd2) >> 2);
               end
               S_MDK_L:  ml_in = ires;
               S_MDK_R:  mr_in = ires;
               S_DUCK_A: begin
                  abs_sum = 22'(abs21(ml_ff)) + 22'(abs21(mr_ff));
                  mus_env = ((24'(abs_sum) << 1) + 24'(abs_sum) + 24'd2) >> 2;
                  lvl     = (mus_env > 24'(K_MUS_MAX)) ? 15'(K_MUS_MAX) : mus_env[14:0];
                  dk_in   = 17'(K_ONE) - 17'(lvl);
               end
               S_ADK_L:  al_in = ires;
               S_ADK_R:  ar_in = ires;
               S_SUM: begin
                  al_in = al_ff + ml_ff + wl_ff;
                  ar_in = ar_ff + mr_ff + wr_ff;
               end
               S_SC_PRE, S_SC_PRE2: t_in = ires;
               S_SC_SEG1, S_SC_SEG2: seg_in = lut_seg;
               S_SC_INT1, S_SC_INT2: t_in = seg_ff.neg ? -ires : ires;
               S_SC_GAIN: y_in = ires;
               S_SC_FIN: begin
                  // Second stage only above the knee
                  fin = (abs21(y_ff) > 21'(K_KNEE)) ? ires : y_ff;
                  if (ch_ff) begin
                     yr_in = fin;
                  end else begin
                     yl_in   = fin;
                     ch_in   = 1'b1;
                     step_in = S_SC_PRE;
                  end
               end
               S_ENV_A: begin
                  acc_in = mac_res;
                  up_in  = up_now;
               end
               S_ENV_B:  env_in = sat18(mac_res);
               S_GAIN_CHK: begin
                  big_in = (env_ff > 18'd65536);
                  if (env_ff > 18'd65536) begin
                     state_in = ST_DIV;
                     dcnt_in  = '0;
                     rem_in   = 19'd65536;
                     quo_in   = '0;
                  end
               end
               S_GAIN_A: acc_in = mac_res;
               S_GAIN_B: gs_in  = sat18(mac_res);
               S_OUT_L1, S_OUT_R1: t_in = ires;
               S_OUT_L2: ol_in = sat16(mac_res);
               S_OUT_R2: begin
                  or_in    = sat16(mac_res);
                  state_in = ST_WAIT;
               end
               default: step_in = step_ff + 5'd1;
            endcase
         end
         ST_DIV: begin
            // One quotient bit a cycle of 2^32 / envelope
            if (rem_sh >= {1'b0, env_ff}) begin
               rem_in = rem_sh - {1'b0, env_ff};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 4'd1;
            if (dcnt_ff == 4'd15) begin
               state_in = ST_RUN;
               step_in  = S_GAIN_A;
            end
         end
         ST_WAIT: begin
            // Hand the frame to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               lr_sum       = 17'(ol_ff) + 17'(or_ff);
               out_l_in     = ol_ff;
               out_r_in     = or_ff;
               mono_in      = lr_sum[16:1];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= S_AMB_L;
         ch_ff        <= 1'b0;
         up_ff        <= 1'b0;
         big_ff       <= 1'b0;
         dcnt_ff      <= '0;
         ag_ff        <= 15'd16384;
         mg_ff        <= 15'd9011;
         wg_ff        <= 15'd0;
         gm_ff        <= 15'd16384;
         men_ff       <= 1'b1;
         env_ff       <= '0;
         gs_ff        <= 18'd65536;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ch_ff        <= ch_in;
         up_ff        <= up_in;
         big_ff       <= big_in;
         dcnt_ff      <= dcnt_in;
         ag_ff        <= ag_in;
         mg_ff        <= mg_in;
         wg_ff        <= wg_in;
         gm_ff        <= gm_in;
         men_ff       <= men_in;
         env_ff       <= env_in;
         gs_ff        <= gs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      s_al_ff  <= s_al_in;
      s_ar_ff  <= s_ar_in;
      s_ml_ff  <= s_ml_in;
      s_mr_ff  <= s_mr_in;
      s_wl_ff  <= s_wl_in;
      s_wr_ff  <= s_wr_in;
      al_ff    <= al_in;
      ar_ff    <= ar_in;
      ml_ff    <= ml_in;
      mr_ff    <= mr_in;
      wl_ff    <= wl_in;
      wr_ff    <= wr_in;
      t_ff     <= t_in;
      y_ff     <= y_in;
      yl_ff    <= yl_in;
      yr_ff    <= yr_in;
      dk_ff    <= dk_in;
      acc_ff   <= acc_in;
      seg_ff   <= seg_in;
      ol_ff    <= ol_in;
      or_ff    <= or_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
      mono_ff  <= mono_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_left  = out_l_ff;
   assign rsp_out_right = out_r_ff;
   assign rsp_mono_mix  = mono_ff;

`ifndef NO_ASSERTIONS
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      gs_ff <= 18'd65536)
      else $error("limiter gain above one");

   a_div_only_loud: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> env_ff > 18'd65536)
      else $error("divider running with envelope at or below one");

   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_RUN && step_ff == S_AMB_L)
      else $error("accepted beat did not start the sequencer");

   a_wait_hand: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT && (!rsp_valid_ff || rsp_ready)
      |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished frame not moved to output register");
`endif

endmodule

/* bench/tb_stereo_duck_softclip_limiter_top.sv */
// Self-checking testbench for the stereo duck, soft-clip and limiter mixer.
`timescale 1ns / 1ps

module tb_stereo_duck_softclip_limiter_top;
   import sdsl_pkg::*;

   localparam logic [2:0] CSR_SPARE_LO = 3'd5;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         DRAIN_CYCLES = 120;

   typedef struct {
      logic signed [15:0] amb_l;
      logic signed [15:0] amb_r;
      logic signed [15:0] mus_l;
      logic signed [15:0] mus_r;
      logic signed [15:0] wea_l;
      logic signed [15:0] wea_r;
   } frame_type;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [15:0] mono;
   } mix_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_ambience_left = '0;
   logic signed [15:0] req_ambience_right = '0;
   logic signed [15:0] req_music_left = '0;
   logic signed [15:0] req_music_right = '0;
   logic signed [15:0] req_weather_left = '0;
   logic signed [15:0] req_weather_right = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_left;
   logic signed [15:0] rsp_out_right;
   logic signed [15:0] rsp_mono_mix;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [14:0]        csr_wdata = '0;

   stereo_duck_softclip_limiter_top dut (.*);

   always #1 clock = ~clock;

   // Mixer state as the bench sees it
   longint amb_gain, mus_gain, wea_level, mst_gain, mus_on;
   longint lim_env, lim_gain;
   longint tanh_lut [TANH_TABLE_DEPTH + 1];

   frame_type frames_pending [$];
   mix_type   mixes_expected [$];
   frame_type drv_frame;
   int        mismatches = 0;
   int        cycles = 0;
   bit        steady = 0;

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   // Fill tanh(4*i/DEPTH) in Q16: Taylor exp(-2x) at 1/256 scale, then squarings
   function automatic void fill_tanh_lut();
      longint unsigned xq, t, t2, t3, t4, e, num, den;
      longint          es;
      for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
         xq = (longint'(i) << 18) / TANH_TABLE_DEPTH;
         t  = xq << 7;
         t2 = (t * t) >> 30;
         t3 = (t2 * t) >> 30;
         t4 = (t3 * t) >> 30;
         es = (longint'(1) << 30) - longint'(t) + longint'(t2 / 2) - longint'(t3 / 6)
              + longint'(t4 / 24);
         if (es < 0) es = 0;
         if (es > (longint'(1) << 30)) es = longint'(1) << 30;
         e = es;
         for (int k = 0; k < 8; k++) e = (e * e) >> 30;
         num = ((64'd1 << 30) - e) << 16;
         den = (64'd1 << 30) + e;
         tanh_lut[i] = longint'((num + den / 2) / den);
      end
   endfunction

   function automatic longint tanh_interp(longint x);
      longint a, p, idx, f, y;
      a = mag(x);
      if (a >= (longint'(4) <<< 16)) begin
         y = tanh_lut[TANH_TABLE_DEPTH];
      end else begin
         p   = a * TANH_TABLE_DEPTH;
         idx = p >>> 18;
         f   = p & ((longint'(1) <<< 18) - 1);
         y   = tanh_lut[idx] + (((tanh_lut[idx + 1] - tanh_lut[idx]) * f) >>> 18);
      end
      return x < 0 ? -y : y;
   endfunction

   function automatic longint soft_clip(longint v);
      longint y;
      y = round_shift(tanh_interp(round_shift(v * 55706, 16)) * 75366, 16);
      if (mag(y) > 58982)
         y = round_shift(58982 * tanh_interp(round_shift(y * 80100, 16)), 16);
      return y;
   endfunction

   function automatic longint clamp16(longint v);
      return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
   endfunction

   function automatic longint clamp18(longint v);
      return v < 0 ? 0 : (v > 262143 ? 262143 : v);
   endfunction

   // Mix one frame and advance the limiter state
   function automatic mix_type mix_frame(frame_type fr);
      longint  al, ar, ml, mr, wl, wr, env, duck, yl, yr, peak, g, ol, orr;
      mix_type m;
      al = round_shift(longint'(fr.amb_l) * amb_gain, 13);
      ar = round_shift(longint'(fr.amb_r) * amb_gain, 13);
      ml = mus_on ? round_shift(longint'(fr.mus_l) * mus_gain, 13) : 0;
      mr = mus_on ? round_shift(longint'(fr.mus_r) * mus_gain, 13) : 0;
      wl = round_shift(round_shift(longint'(fr.wea_l) * wea_level, 13) * 9011, 14);
      wr = round_shift(round_shift(longint'(fr.wea_r) * wea_level, 13) * 9011, 14);
      // duck music by weather, then ambience by music
      env = mag(wl) + mag(wr);
      if (env > 22938) env = 22938;
      duck = 65536 - round_shift(env, 2);
      ml = round_shift(ml * duck, 16);
      mr = round_shift(mr * duck, 16);
      env = round_shift((mag(ml) + mag(mr)) * 3, 2);
      if (env > 13107) env = 13107;
      duck = 65536 - env;
      al = round_shift(al * duck, 16);
      ar = round_shift(ar * duck, 16);
      yl = soft_clip(al + ml + wl);
      yr = soft_clip(ar + mr + wr);
      // peak envelope and smoothed limiter gain
      peak = mag(yl) > mag(yr) ? mag(yl) : mag(yr);
      if (peak > lim_env) lim_env = round_shift(lim_env * 60293 + peak * 5243, 16);
      else lim_env = round_shift(lim_env * 65208 + peak * 328, 16);
      lim_env = clamp18(lim_env);
      if (lim_env > 65536) begin
         g = longint'((64'd1 << 32) / longint'(lim_env));
         if (g < 39322) g = 39322;
         if (g > 65536) g = 65536;
         lim_gain = round_shift(lim_gain * 58982 + g * 6554, 16);
      end else begin
         lim_gain = round_shift(lim_gain * 65208 + longint'(65536) * 328, 16);
      end
      lim_gain = clamp18(lim_gain);
      ol  = clamp16(round_shift(round_shift(yl * lim_gain, 16) * mst_gain, 15));
      orr = clamp16(round_shift(round_shift(yr * lim_gain, 16) * mst_gain, 15));
      m.left  = ol[15:0];
      m.right = orr[15:0];
      m.mono  = 16'((ol + orr) >>> 1);
      return m;
   endfunction

   // Mostly short gaps, a few long ones, none while in a steady stretch
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Request driver: hold a beat until accepted, predict on acceptance
   int req_gap = 0;
   always @(posedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (!reset) begin
         if (req_valid && req_ready) begin
            mixes_expected.push_back(mix_frame(drv_frame));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (frames_pending.size() > 0) begin
               drv_frame = frames_pending.pop_front();
               req_ambience_left  <= drv_frame.amb_l;
               req_ambience_right <= drv_frame.amb_r;
               req_music_left     <= drv_frame.mus_l;
               req_music_right    <= drv_frame.mus_r;
               req_weather_left   <= drv_frame.wea_l;
               req_weather_right  <= drv_frame.wea_r;
               next_valid = 1'b1;
               req_gap = pick_gap();
               if ($urandom_range(99) < 3) steady = !steady;
            end
         end
      end
      req_valid <= next_valid;
   end

   // Result monitor with random back-pressure
   int rsp_gap = 0;
   always @(posedge clock) begin
      mix_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (mixes_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat L=%0d R=%0d M=%0d",
                  rsp_out_left, rsp_out_right, rsp_mono_mix);
            end else begin
               want = mixes_expected.pop_front();
               if (rsp_out_left !== want.left || rsp_out_right !== want.right ||
                   rsp_mono_mix !== want.mono) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected L=%0d R=%0d M=%0d, got L=%0d R=%0d M=%0d",
                        want.left, want.right, want.mono,
                        rsp_out_left, rsp_out_right, rsp_mono_mix);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(99) < 30) rsp_gap = pick_gap();
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [14:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_AMB_GAIN:  amb_gain  = val;
         CSR_MUS_GAIN:  mus_gain  = val;
         CSR_WEA_LEVEL: wea_level = val > 16384 ? 16384 : val;
         CSR_MST_GAIN:  mst_gain  = val;
         CSR_MUS_EN:    mus_on    = val[0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_frame(int al, int ar, int ml, int mr, int wl, int wr);
      frame_type fr;
      fr.amb_l = 16'(al); fr.amb_r = 16'(ar); fr.mus_l = 16'(ml);
      fr.mus_r = 16'(mr); fr.wea_l = 16'(wl); fr.wea_r = 16'(wr);
      frames_pending.push_back(fr);
   endtask

   // Random sample: full range, small level or an extreme
   function automatic int rand_sample();
      int r;
      r = $urandom_range(99);
      if (r < 50) return $signed(16'($urandom));
      if (r < 85) return $urandom_range(0, 8000) - 4000;
      return r < 92 ? 32767 : -32768;
   endfunction

   function automatic logic [14:0] rand_gain();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 15'd0;
      if (r < 20) return 15'h7fff;
      return 15'($urandom_range(0, 32767));
   endfunction

   task automatic drain();
      wait (frames_pending.size() == 0 && !req_valid && mixes_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      fill_tanh_lut();
      amb_gain = 16384; mus_gain = 9011; wea_level = 0; mst_gain = 16384; mus_on = 1;
      lim_env = 0; lim_gain = 65536;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed frames at reset settings
      queue_frame(0, 0, 0, 0, 0, 0);
      queue_frame(32767, 32767, 32767, 32767, 32767, 32767);
      queue_frame(-32768, -32768, -32768, -32768, -32768, -32768);
      queue_frame(32767, -32768, -32768, 32767, 32767, -32768);
      queue_frame(1, -1, 1, -1, 1, -1);
      drain();

      // Loud settings: full weather ducking, overdriven gains
      csr_write(CSR_AMB_GAIN, 15'h7fff);
      csr_write(CSR_MUS_GAIN, 15'h7fff);
      csr_write(CSR_WEA_LEVEL, 15'h7fff);  // clamps to full
      csr_write(CSR_MST_GAIN, 15'h7fff);
      csr_write(CSR_SPARE_LO, 15'd0);      // unmapped, no effect
      for (int i = 0; i < 8; i++)
         queue_frame(i[0] ? 32767 : -32768, 32767, -32768, 32767, i[1] ? 32767 : -32768,
                     -32768);
      queue_frame(0, 0, 0, 0, 0, 0);
      drain();

      // Zero ambience, music and master gains, full weather level, music muted
      csr_write(CSR_AMB_GAIN, 15'd0);
      csr_write(CSR_MUS_GAIN, 15'd0);
      csr_write(CSR_WEA_LEVEL, 15'd16384);
      csr_write(CSR_MST_GAIN, 15'd0);
      csr_write(CSR_MUS_EN, 15'd0);
      csr_write(CSR_SPARE_HI, 15'h7fff);
      queue_frame(32767, -32768, 32767, -32768, 32767, -32768);
      queue_frame(-32768, 32767, -32768, 32767, 0, 0);
      drain();

      // Random phases, each with its own settings
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_AMB_GAIN, rand_gain());
         csr_write(CSR_MUS_GAIN, rand_gain());
         csr_write(CSR_WEA_LEVEL, $urandom_range(99) < 20 ? 15'd16384 : rand_gain());
         csr_write(CSR_MST_GAIN, $urandom_range(99) < 50 ? 15'd16384 : rand_gain());
         csr_write(CSR_MUS_EN, 15'($urandom_range(99) < 75));
         if ($urandom_range(1)) csr_write(3'($urandom_range(5, 7)), 15'($urandom));
         for (int i = 0; i < 118; i++)
            queue_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                        rand_sample(), rand_sample());
         drain();
      end

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
